// ===== rtl/core/spq_pkg.sv =====
// Shared types, codes and defaults for the sorted priority queue.
package spq_pkg;

  // Default configuration
  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_BITS_DEF = 8;
  localparam int DATA_BITS_DEF = 32;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_PUSHED    = 2'd0;
  localparam logic [1:0] ST_DEQUEUED  = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY = 2'd2;
  localparam logic [1:0] ST_PUSH_FULL = 2'd3;

  typedef struct packed {
    logic               op;
    logic [7:0]         priority_req;
    logic signed [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         out_priority;
    logic signed [31:0] out_payload;
    logic [4:0]         occupancy;
  } out_item_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;  // insert the new entry (queue not full)
    logic pop;   // shift everything toward the head (queue not empty)
  } spq_cmd_t;

endpackage

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, fill count and result register.
//
// Bounded priority queue held as a chain of DEPTH cells in falling priority
// order, head in cell 0. Every cell compares its own entry against a pushed
// one in the same cycle: the block takes one item per cycle while the result
// register is free or draining, and an item's result appears in the output
// register in the cycle after acceptance. Equal priorities leave first in,
// first out. A push to a full queue is dropped and reported; a pop on empty
// is reported too. The output register is the only buffer, so input ready
// follows "result register empty or being taken this cycle".
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic                 in_fire;
  logic                 full;
  logic                 empty;
  spq_cmd_t             cmd;
  logic [PRIO_BITS-1:0] new_prio;
  logic [DATA_BITS-1:0] new_data;
  logic [PRIO_BITS-1:0] prio_q   [DEPTH];
  logic [DATA_BITS-1:0] data_q   [DEPTH];
  logic                 behind_q [DEPTH];

  // Accept while the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  assign new_prio = PRIO_BITS'(in_item.priority_req);
  assign new_data = DATA_BITS'(in_item.payload);

  assign cmd.push = in_fire && (in_item.op == OP_PUSH) && !full;
  assign cmd.pop  = in_fire && (in_item.op == OP_POP) && !empty;

  // Build the chain; cell 0 sees the new entry on its left
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_behind;
    logic [PRIO_BITS-1:0] l_prio, r_prio;
    logic [DATA_BITS-1:0] l_data, r_data;

    if (i == 0) begin : g_head
      assign l_behind = 1'b1;
      assign l_prio   = new_prio;
      assign l_data   = new_data;
    end else begin : g_body
      assign l_behind = behind_q[i-1];
      assign l_prio   = prio_q[i-1];
      assign l_data   = data_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_prio = prio_q[i];
      assign r_data = data_q[i];
    end else begin : g_mid
      assign r_prio = prio_q[i+1];
      assign r_data = data_q[i+1];
    end

    spq_cell #(
      .PRIO_BITS (PRIO_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CNT_W'(i) < count_r),
      .new_prio    (new_prio),
      .new_data    (new_data),
      .left_behind (l_behind),
      .left_prio   (l_prio),
      .left_data   (l_data),
      .right_prio  (r_prio),
      .right_data  (r_data),
      .prio        (prio_q[i]),
      .data        (data_q[i]),
      .behind      (behind_q[i])
    );
  end

  // Update fill count and form the result
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.out_priority = '0;
      out_item_nxt.out_payload  = '0;
      if (in_item.op == OP_PUSH) begin
        if (full) begin
          out_item_nxt.status = ST_PUSH_FULL;
        end else begin
          out_item_nxt.status = ST_PUSHED;
          count_nxt           = count_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          out_item_nxt.status = ST_POP_EMPTY;
        end else begin
          out_item_nxt.status       = ST_DEQUEUED;
          out_item_nxt.out_priority = 8'(prio_q[0]);
          out_item_nxt.out_payload  = 32'(data_q[0]);
          count_nxt                 = count_r - CNT_W'(1);
        end
      end
      out_item_nxt.occupancy = 5'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Fill count stays within the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  // Pop on a non-empty queue yields a dequeued result
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_item.op == OP_POP) && !empty |=>
      out_valid_r && (out_item_r.status == ST_DEQUEUED))
    else $error("pop did not dequeue");

  // Accepted push into free space grows the count by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_item.op == OP_PUSH) && !full |=>
      count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow fill count");

  // Pending result reports the current fill count
  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.occupancy == 5'(count_r))
    else $error("reported occupancy mismatches fill count");

endmodule

// ===== rtl/core/spq_cell.sv =====
// One storage cell of the sorted shift chain: entry registers and local compare.
module spq_cell import spq_pkg::*; #(
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  spq_cmd_t             cmd,
  input  logic                 occupied,
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic [DATA_BITS-1:0] new_data,
  input  logic                 left_behind,
  input  logic [PRIO_BITS-1:0] left_prio,
  input  logic [DATA_BITS-1:0] left_data,
  input  logic [PRIO_BITS-1:0] right_prio,
  input  logic [DATA_BITS-1:0] right_data,
  output logic [PRIO_BITS-1:0] prio,
  output logic [DATA_BITS-1:0] data,
  output logic                 behind
);

  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [DATA_BITS-1:0] data_r, data_nxt;

  // New entry goes behind this one if held with greater or equal priority
  assign behind = occupied && (prio_r >= new_prio);

  // Select next contents: hold, take new entry, shift from left or right
  always_comb begin
    prio_nxt = prio_r;
    data_nxt = data_r;
    if (cmd.push) begin
      if (!behind) begin
        if (left_behind) begin
          prio_nxt = new_prio;
          data_nxt = new_data;
        end else begin
          prio_nxt = left_prio;
          data_nxt = left_data;
        end
      end
    end else if (cmd.pop) begin
      prio_nxt = right_prio;
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    data_r <= data_nxt;
  end

  assign prio = prio_r;
  assign data = data_r;

endmodule

// ===== verif/spq_result_checker.sv =====
// Result checker for the sorted priority queue: predicts every item and compares results.
module spq_result_checker import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatches,
  output int        pending
);

  localparam int MAX_REPORTS = 10;

  // Shadow copy of the queue, kept in falling priority order, head at index 0
  logic [7:0]         held_prio [DEPTH];
  logic signed [31:0] held_data [DEPTH];
  int                 held_count;

  // Results owed by the block, oldest first
  out_item_t          owed_results [$];

  // Apply one item to the shadow queue and build the result it must produce
  task automatic apply_queue_item(input in_item_t it, output out_item_t res);
    int pos;
    res = '0;
    if (it.op == OP_PUSH) begin
      if (held_count >= DEPTH) begin
        res.status = ST_PUSH_FULL;
      end else begin
        // go behind every entry of greater or equal priority, so ties leave in arrival order
        pos = 0;
        while (pos < held_count && held_prio[pos] >= it.priority_req) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_prio[i] = held_prio[i-1];
          held_data[i] = held_data[i-1];
        end
        held_prio[pos] = it.priority_req;
        held_data[pos] = it.payload;
        held_count++;
        res.status = ST_PUSHED;
      end
    end else if (held_count == 0) begin
      res.status = ST_POP_EMPTY;
    end else begin
      // take the head and advance the rest toward it
      res.out_priority = held_prio[0];
      res.out_payload  = held_data[0];
      for (int i = 1; i < held_count; i++) begin
        held_prio[i-1] = held_prio[i];
        held_data[i-1] = held_data[i];
      end
      held_count--;
      res.status = ST_DEQUEUED;
    end
    res.occupancy = 5'(held_count);
  endtask

  // Check results against the oldest expectation, then predict the newly accepted item
  always @(posedge clk) begin : watch_channels
    out_item_t want;
    out_item_t res;
    if (!rst_n) begin
      held_count = 0;
      owed_results.delete();
      mismatches = 0;
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result: status %0d prio %0d payload %0d occupancy %0d",
                     out_item.status, out_item.out_priority, out_item.out_payload,
                     out_item.occupancy);
          mismatches = mismatches + 1;
        end else begin
          want = owed_results.pop_front();
          if (out_item.status !== want.status ||
              out_item.out_priority !== want.out_priority ||
              out_item.out_payload !== want.out_payload ||
              out_item.occupancy !== want.occupancy) begin
            if (mismatches < MAX_REPORTS)
              $display({"mismatch: expected st %0d pr %0d pl %0d occ %0d,",
                        " got st %0d pr %0d pl %0d occ %0d"},
                       want.status, want.out_priority, want.out_payload, want.occupancy,
                       out_item.status, out_item.out_priority, out_item.out_payload,
                       out_item.occupancy);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_queue_item(in_item, res);
        owed_results.push_back(res);
      end
      pending = owed_results.size();
    end
  end

endmodule

// ===== verif/tb_sorted_priority_queue.sv =====
// Testbench top for the sorted priority queue: clock, reset, stimulus, back-pressure and verdict.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 930;
  localparam int QUIET_ITEMS  = 150;
  localparam int LONG_HOLD    = 64;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int        mismatches;
  int        pending;
  int        cycle_count = 0;
  bit        quiet       = 1'b0;
  bit        hold_req    = 1'b0;
  bit        hold_done   = 1'b0;

  always #1 clk = ~clk;

  sorted_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  spq_result_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic op, logic [7:0] prio, logic [31:0] data);
    in_item_t it;
    it.op           = op;
    it.priority_req = prio;
    it.payload      = data;
    return it;
  endfunction

  // Offer one item, with an occasional idle burst ahead of it, and hold until accepted
  task automatic offer_item(input in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: ready runs, stall bursts and one long hold-off
  initial begin : receiver
    int stall;
    int run;
    wait (rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 11);
        repeat (stall) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        run = $urandom_range(1, 16);
        repeat (run) begin
          @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    int       push_pct;
    int       phase_len;
    int       tie_base;
    int       pick;
    int       sent;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Pop on empty, extremes, ties at the ends and middle, fill to full, push on full
    offer_item(make_item(OP_POP,  8'd0,   32'h0));
    offer_item(make_item(OP_PUSH, 8'd255, 32'h7FFF_FFFF));
    offer_item(make_item(OP_PUSH, 8'd0,   32'h8000_0000));
    offer_item(make_item(OP_PUSH, 8'd128, 32'h0));
    offer_item(make_item(OP_PUSH, 8'd128, 32'hFFFF_FFFF));
    offer_item(make_item(OP_PUSH, 8'd128, 32'h1));
    offer_item(make_item(OP_PUSH, 8'd0,   32'h5));
    offer_item(make_item(OP_PUSH, 8'd255, 32'h7));
    offer_item(make_item(OP_PUSH, 8'd1,   32'h5555_5555));
    offer_item(make_item(OP_PUSH, 8'd2,   32'hAAAA_AAAA));
    offer_item(make_item(OP_PUSH, 8'd254, 32'h1234_5678));
    offer_item(make_item(OP_PUSH, 8'd127, 32'hDEAD_BEEF));
    offer_item(make_item(OP_PUSH, 8'd64,  32'h0F0F_0F0F));
    offer_item(make_item(OP_PUSH, 8'd200, 32'hF0F0_F0F0));
    offer_item(make_item(OP_PUSH, 8'd100, 32'h0000_FFFF));
    offer_item(make_item(OP_PUSH, 8'd128, 32'hFFFF_0000));
    offer_item(make_item(OP_PUSH, 8'd99,  32'hCAFE_F00D));
    offer_item(make_item(OP_PUSH, 8'd255, 32'h0BAD_0BAD));
    repeat (5) offer_item(make_item(OP_POP, 8'hFF, 32'hFFFF_FFFF));
    drain_results();

    // Random phases, each leaning toward push, balance or pop, with clustered priorities for ties
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      phase_len = $urandom_range(10, 60);
      tie_base  = $urandom_range(0, 255);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        it.op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
        pick  = $urandom_range(0, 9);
        if (pick < 4)
          it.priority_req = 8'(tie_base + $urandom_range(0, 2));
        else if (pick == 4)
          it.priority_req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
          it.priority_req = 8'($urandom);
        it.payload = $urandom;
        offer_item(it);
        sent++;
        if (sent == 300) hold_req = 1'b1;
        if (sent == 600) drain_results();
        if (sent == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
